>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of the sample chain.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ODP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define ODP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/odp_pkg.sv
// Shared types, constants and fixed-point helpers of the overdrive sample chain.
`timescale 1ns / 1ps
`default_nettype none
package odp_pkg;

  localparam int CHANNELS_DEF = 2;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_DRIVE = 3'd0;
  localparam logic [2:0] REG_LEVEL = 3'd1;
  localparam logic [2:0] REG_HPC   = 3'd2;
  localparam logic [2:0] REG_MIDC  = 3'd3;
  localparam logic [2:0] REG_TONEC = 3'd4;

  // Divider geometry: quotient bits, numerator and divisor widths.
  localparam int DIV_QW = 17;
  localparam int DIV_NW = 57;
  localparam int DIV_DW = 39;

  // Multiplier operand and product widths.
  localparam int MA_W = 26;
  localparam int MB_W = 25;
  localparam int MP_W = MA_W + MB_W;

  // Fixed-point constants in Q0.16 / Q8.16; K27 is scaled by 2^32.
  localparam logic signed [63:0] ONE_Q16  = 64'sd65536;
  localparam logic signed [63:0] CLIP_POS = 64'sd36045;
  localparam logic signed [63:0] CLIP_NEG = 64'sd27034;
  localparam logic signed [63:0] TANH_LIM = 64'sd196608;
  localparam logic signed [63:0] K27      = 64'sd115964116992;
  localparam logic signed [24:0] MIX_DRY  = 25'sd45875;
  localparam logic signed [24:0] MIX_MID  = 25'sd19661;
  localparam logic signed [24:0] TANH_SC  = 25'sd58982;

  typedef struct packed {
    logic [16:0] drive;
    logic [16:0] level;
    logic [15:0] hpc;
    logic [15:0] midc;
    logic [15:0] tonec;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_HP1_MUL, OP_HP1_ADD, OP_MID_MUL, OP_MID_ADD, OP_DRY,
    OP_WET_LO, OP_WET_HI, OP_WET_SUM, OP_GAIN_MUL, OP_GAIN, OP_CLIP_LOAD,
    OP_CLIP_END, OP_TONE_MUL, OP_TONE_ADD, OP_LVL_MUL, OP_LVL, OP_HP2_MUL,
    OP_HP2_ADD, OP_TS_MUL, OP_TS, OP_SQ, OP_NPREP, OP_NLO, OP_NHI, OP_NSUM,
    OP_FINISH
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_HP1_MUL, S_HP1_ADD, S_MID_MUL, S_MID_ADD, S_DRY, S_WET_LO,
    S_WET_HI, S_WET_SUM, S_GAIN_MUL, S_GAIN, S_CLIP_LOAD, S_CLIP_WAIT,
    S_CLIP_END, S_TONE_MUL, S_TONE_ADD, S_LVL_MUL, S_LVL, S_HP2_MUL,
    S_HP2_ADD, S_TS_MUL, S_TS, S_SQ, S_NPREP, S_NLO, S_NHI, S_NSUM,
    S_TANH_WAIT, S_FINISH
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  // Saturate to the signed 24-bit range.
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    else if (v < -64'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  // Round half up, then drop 16 fraction bits.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  // Round half up, then drop 32 fraction bits.
  function automatic logic signed [63:0] rnd32(input logic signed [63:0] v);
    return (v + 64'sd2147483648) >>> 32;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/odp_ifs.sv
// Valid/ready stream interfaces for sample beats in and out of the chain.
`timescale 1ns / 1ps
`default_nettype none
interface odp_in_if;
  logic               valid;
  logic               ready;
  logic               channel;
  logic signed [15:0] in_sample;
  modport source (output valid, channel, in_sample, input ready);
  modport sink (input valid, channel, in_sample, output ready);
endinterface

interface odp_out_if;
  logic               valid;
  logic               ready;
  logic               out_channel;
  logic signed [15:0] out_sample;
  modport source (output valid, out_channel, out_sample, input ready);
  modport sink (input valid, out_channel, out_sample, output ready);
endinterface
`default_nettype wire

>>> rtl/core/odp_regs.sv
// Configuration register file with clamping of drive and level.
`timescale 1ns / 1ps
`default_nettype none
module odp_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [16:0]   cfg_wdata,
  output odp_pkg::cfg_t cfg
);

  odp_pkg::cfg_t cfg_r, cfg_nxt;
  logic [16:0]   v17;

  // Drive and level above unity are held at unity.
  assign v17 = (cfg_wdata > 17'd65536) ? 17'd65536 : cfg_wdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        odp_pkg::REG_DRIVE: cfg_nxt.drive = v17;
        odp_pkg::REG_LEVEL: cfg_nxt.level = v17;
        odp_pkg::REG_HPC:   cfg_nxt.hpc   = cfg_wdata[15:0];
        odp_pkg::REG_MIDC:  cfg_nxt.midc  = cfg_wdata[15:0];
        odp_pkg::REG_TONEC: cfg_nxt.tonec = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive <= 17'd32768;
      cfg_r.level <= 17'd32768;
      cfg_r.hpc   <= 16'd65208;
      cfg_r.midc  <= 16'd6119;
      cfg_r.tonec <= 16'd22000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> rtl/core/odp_div.sv
// Restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module odp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [odp_pkg::DIV_NW-1:0]  num,
  input  logic [odp_pkg::DIV_DW-1:0]  den,
  output logic [odp_pkg::DIV_QW-1:0]  quo,
  output logic                        done
);

  localparam int QW = odp_pkg::DIV_QW;
  localparam int NW = odp_pkg::DIV_NW;
  localparam int CW = $clog2(QW);

  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] dsr_r, dsr_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  // The quotient is known to stay below 2^QW, so the divisor starts
  // shifted up by QW-1 and walks down one bit per step.
  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsr_nxt  = NW'(den) << (QW - 1);
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= dsr_r) begin
        rem_nxt = rem_r - dsr_r;
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule
`default_nettype wire

>>> rtl/core/odp_dp.sv
// Datapath: filter state, one shared multiplier, divider and output register.
`timescale 1ns / 1ps
`default_nettype none
module odp_dp #(
  parameter int CHANNELS = odp_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  odp_pkg::cmd_t      cmd,
  input  odp_pkg::cfg_t      cfg,
  input  logic               in_channel,
  input  logic signed [15:0] in_sample,
  output odp_pkg::status_t   status,
  output logic               out_channel,
  output logic signed [15:0] out_sample
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MA_W = odp_pkg::MA_W;
  localparam int MB_W = odp_pkg::MB_W;
  localparam int MP_W = odp_pkg::MP_W;
  localparam int NW   = odp_pkg::DIV_NW;
  localparam int DW   = odp_pkg::DIV_DW;
  localparam int QW   = odp_pkg::DIV_QW;

  // Per-channel filter memories.
  logic signed [23:0] hp1_mem_r  [CHANNELS];
  logic signed [23:0] mid_mem_r  [CHANNELS];
  logic signed [23:0] tone_mem_r [CHANNELS];
  logic signed [23:0] hp2_mem_r  [CHANNELS];
  logic               we_hp1, we_mid, we_tone, we_hp2;

  logic               ch_r, ch_nxt;
  logic [CH_W-1:0]    idx_r, idx_nxt;
  logic signed [16:0] x_r, x_nxt;
  logic [22:0]        g_r, g_nxt;
  logic signed [23:0] s_r, s_nxt;
  logic signed [23:0] mid_r, mid_nxt;
  logic signed [24:0] t_r, t_nxt;
  logic signed [38:0] q_r, q_nxt;
  logic [37:0]        acc_r, acc_nxt;
  logic               pos_r, pos_nxt, neg_r, neg_nxt;
  logic               vsp_r, vsp_nxt, vsn_r, vsn_nxt, vneg_r, vneg_nxt;
  logic [17:0]        av_r, av_nxt;
  logic [37:0]        n_r, n_nxt;
  logic [DW-1:0]      den_r, den_nxt;
  logic               och_r, och_nxt;
  logic signed [15:0] osamp_r, osamp_nxt;
  logic signed [MP_W-1:0] p_r, p_nxt;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;

  logic signed [23:0] z_hp1, z_mid, z_tone, z_hp2;
  logic signed [63:0] gv, dv, uv, vv, avv, yv, ov, qs, wet;
  logic [23:0]        dd, uu;
  logic [63:0]        v2w;
  logic               div_start, div_done;
  logic [NW-1:0]      div_num;
  logic [DW-1:0]      div_den;
  logic [QW-1:0]      div_q;

  assign z_hp1  = hp1_mem_r[idx_r];
  assign z_mid  = mid_mem_r[idx_r];
  assign z_tone = tone_mem_r[idx_r];
  assign z_hp2  = hp2_mem_r[idx_r];

  // Helper terms for the gain, clipper and tanh steps.
  assign gv  = 64'sd65536 + $signed(64'(cfg.drive)) * 64'sd109;
  assign dv  = 64'(s_r) - odp_pkg::CLIP_POS;
  assign uv  = -64'(s_r) - odp_pkg::CLIP_NEG;
  assign dd  = dv[23:0];
  assign uu  = uv[23:0];
  assign vv  = odp_pkg::rnd16(64'(p_r));
  assign avv = (vv < 64'sd0) ? -vv : vv;
  assign v2w = 64'(p_r[35:0]);
  assign qs  = $signed(64'(div_q));
  assign wet = (64'(p_r) <<< 20) + $signed(64'(acc_r));

  // Command decode: operand select for the multiplier and next register values.
  always_comb begin
    ch_nxt = ch_r; idx_nxt = idx_r; x_nxt = x_r; g_nxt = g_r;
    s_nxt = s_r; mid_nxt = mid_r; t_nxt = t_r; q_nxt = q_r; acc_nxt = acc_r;
    pos_nxt = pos_r; neg_nxt = neg_r;
    vsp_nxt = vsp_r; vsn_nxt = vsn_r; vneg_nxt = vneg_r; av_nxt = av_r;
    n_nxt = n_r; den_nxt = den_r; och_nxt = och_r; osamp_nxt = osamp_r;
    ma = '0; mb = '0;
    we_hp1 = 1'b0; we_mid = 1'b0; we_tone = 1'b0; we_hp2 = 1'b0;
    div_start = 1'b0; div_num = '0; div_den = '0;
    yv = '0; ov = '0;
    case (cmd.op)
      odp_pkg::OP_LOAD: begin
        ch_nxt  = in_channel;
        idx_nxt = (CHANNELS > 1) ? CH_W'(in_channel) : '0;
        x_nxt   = {in_sample, 1'b0};
        g_nxt   = gv[22:0];
      end
      odp_pkg::OP_HP1_MUL: begin
        ma = MA_W'(z_hp1);
        mb = MB_W'(cfg.hpc);
      end
      odp_pkg::OP_HP1_ADD: begin
        s_nxt  = odp_pkg::sat24(64'(x_r) - 64'(z_hp1) + odp_pkg::rnd16(64'(p_r)));
        we_hp1 = 1'b1;
      end
      odp_pkg::OP_MID_MUL: begin
        ma = MA_W'(s_r) - MA_W'(z_mid);
        mb = MB_W'(cfg.midc);
      end
      odp_pkg::OP_MID_ADD: begin
        mid_nxt = odp_pkg::sat24(64'(z_mid) + odp_pkg::rnd16(64'(p_r)));
        we_mid  = 1'b1;
        ma      = MA_W'(s_r);
        mb      = odp_pkg::MIX_DRY;
      end
      odp_pkg::OP_DRY: begin
        t_nxt = 25'(odp_pkg::rnd16(64'(p_r)));
        ma    = MA_W'(mid_r);
        mb    = odp_pkg::MIX_MID;
      end
      // The mid term times drive is split into a low and a high partial.
      odp_pkg::OP_WET_LO: begin
        q_nxt = p_r[38:0];
        ma    = MA_W'(p_r[19:0]);
        mb    = MB_W'(cfg.drive);
      end
      odp_pkg::OP_WET_HI: begin
        acc_nxt = p_r[37:0];
        ma      = MA_W'(q_r >>> 20);
        mb      = MB_W'(cfg.drive);
      end
      odp_pkg::OP_WET_SUM: begin
        s_nxt = odp_pkg::sat24(64'(t_r) + odp_pkg::rnd32(wet));
      end
      odp_pkg::OP_GAIN_MUL: begin
        ma = MA_W'(s_r);
        mb = MB_W'(g_r);
      end
      odp_pkg::OP_GAIN: begin
        s_nxt = odp_pkg::sat24(odp_pkg::rnd16(64'(p_r)));
      end
      // Clipper: build numerator and divisor for whichever side applies.
      odp_pkg::OP_CLIP_LOAD: begin
        pos_nxt   = (64'(s_r) > odp_pkg::CLIP_POS);
        neg_nxt   = (64'(s_r) < -odp_pkg::CLIP_NEG);
        div_start = 1'b1;
        if (64'(s_r) > odp_pkg::CLIP_POS) begin
          div_num = NW'(((64'(dd) << 3) + 64'(dd)) << 16);
          div_den = DW'(64'd589824 + (64'(dd) << 5) + (64'(dd) << 4) + (64'(dd) << 1));
        end else begin
          div_num = NW'(((64'(uu) << 5) + (64'(uu) << 3) + (64'(uu) << 2)
                        + (64'(uu) << 1) + 64'(uu)) << 16);
          div_den = DW'(64'd3080192 + (64'(uu) << 7) + (64'(uu) << 6) + (64'(uu) << 3));
        end
      end
      odp_pkg::OP_CLIP_END: begin
        if (pos_r) s_nxt = odp_pkg::sat24(odp_pkg::CLIP_POS + qs);
        else if (neg_r) s_nxt = odp_pkg::sat24(-(odp_pkg::CLIP_NEG + qs));
      end
      odp_pkg::OP_TONE_MUL: begin
        ma = MA_W'(s_r) - MA_W'(z_tone);
        mb = MB_W'(cfg.tonec);
      end
      odp_pkg::OP_TONE_ADD: begin
        s_nxt   = odp_pkg::sat24(64'(z_tone) + odp_pkg::rnd16(64'(p_r)));
        we_tone = 1'b1;
      end
      odp_pkg::OP_LVL_MUL: begin
        ma = MA_W'(s_r);
        mb = MB_W'(cfg.level);
      end
      odp_pkg::OP_LVL: begin
        s_nxt = odp_pkg::sat24(odp_pkg::rnd16(64'(p_r)));
      end
      odp_pkg::OP_HP2_MUL: begin
        ma = MA_W'(z_hp2);
        mb = MB_W'(cfg.hpc);
      end
      odp_pkg::OP_HP2_ADD: begin
        s_nxt  = odp_pkg::sat24(64'(s_r) - 64'(z_hp2) + odp_pkg::rnd16(64'(p_r)));
        we_hp2 = 1'b1;
      end
      odp_pkg::OP_TS_MUL: begin
        ma = MA_W'(s_r);
        mb = odp_pkg::TANH_SC;
      end
      // Tanh argument: saturation flags, sign and magnitude.
      odp_pkg::OP_TS: begin
        vsp_nxt  = (vv >= odp_pkg::TANH_LIM);
        vsn_nxt  = (vv <= -odp_pkg::TANH_LIM);
        vneg_nxt = (vv < 64'sd0);
        av_nxt   = avv[17:0];
      end
      odp_pkg::OP_SQ: begin
        ma = MA_W'(av_r);
        mb = MB_W'(av_r);
      end
      odp_pkg::OP_NPREP: begin
        n_nxt   = 38'(odp_pkg::K27 + $signed(v2w));
        den_nxt = DW'(odp_pkg::K27 + $signed((v2w << 3) + v2w));
      end
      odp_pkg::OP_NLO: begin
        ma = MA_W'(av_r);
        mb = MB_W'(n_r[18:0]);
      end
      odp_pkg::OP_NHI: begin
        acc_nxt = p_r[37:0];
        ma      = MA_W'(av_r);
        mb      = MB_W'(n_r[37:19]);
      end
      odp_pkg::OP_NSUM: begin
        div_start = 1'b1;
        div_num   = NW'((64'(p_r[37:0]) << 19) + 64'(acc_r));
        div_den   = den_r;
      end
      // Final rounding to Q1.15 with saturation.
      odp_pkg::OP_FINISH: begin
        if (vsp_r) yv = odp_pkg::ONE_Q16;
        else if (vsn_r) yv = -odp_pkg::ONE_Q16;
        else if (vneg_r) yv = -qs;
        else yv = qs;
        ov = (yv + 64'sd1) >>> 1;
        if (ov > 64'sd32767) osamp_nxt = 16'sh7FFF;
        else if (ov < -64'sd32768) osamp_nxt = 16'sh8000;
        else osamp_nxt = ov[15:0];
        och_nxt = ch_r;
      end
      default: ;
    endcase
  end

  assign p_nxt = ma * mb;

  odp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  // Filter memories clear on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hp1_mem_r[i]  <= '0;
        mid_mem_r[i]  <= '0;
        tone_mem_r[i] <= '0;
        hp2_mem_r[i]  <= '0;
      end
    end else begin
      if (we_hp1)  hp1_mem_r[idx_r]  <= s_nxt;
      if (we_mid)  mid_mem_r[idx_r]  <= mid_nxt;
      if (we_tone) tone_mem_r[idx_r] <= s_nxt;
      if (we_hp2)  hp2_mem_r[idx_r]  <= s_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    ch_r <= ch_nxt; idx_r <= idx_nxt; x_r <= x_nxt; g_r <= g_nxt;
    s_r <= s_nxt; mid_r <= mid_nxt; t_r <= t_nxt; q_r <= q_nxt; acc_r <= acc_nxt;
    pos_r <= pos_nxt; neg_r <= neg_nxt;
    vsp_r <= vsp_nxt; vsn_r <= vsn_nxt; vneg_r <= vneg_nxt; av_r <= av_nxt;
    n_r <= n_nxt; den_r <= den_nxt; och_r <= och_nxt; osamp_r <= osamp_nxt;
    p_r <= p_nxt;
  end

  assign status.div_done = div_done;
  assign out_channel     = och_r;
  assign out_sample      = osamp_r;

endmodule
`default_nettype wire

>>> rtl/core/odp_ctrl.sv
// Controller: sequences the datapath steps and runs the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module odp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  odp_pkg::status_t status,
  output odp_pkg::cmd_t    cmd
);

  odp_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= odp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and command per step.
  always_comb begin
    state_nxt     = state_r;
    cmd.op        = odp_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      odp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op    = odp_pkg::OP_LOAD;
          state_nxt = odp_pkg::S_HP1_MUL;
        end
      end
      odp_pkg::S_HP1_MUL:  begin cmd.op = odp_pkg::OP_HP1_MUL;  state_nxt = odp_pkg::S_HP1_ADD; end
      odp_pkg::S_HP1_ADD:  begin cmd.op = odp_pkg::OP_HP1_ADD;  state_nxt = odp_pkg::S_MID_MUL; end
      odp_pkg::S_MID_MUL:  begin cmd.op = odp_pkg::OP_MID_MUL;  state_nxt = odp_pkg::S_MID_ADD; end
      odp_pkg::S_MID_ADD:  begin cmd.op = odp_pkg::OP_MID_ADD;  state_nxt = odp_pkg::S_DRY; end
      odp_pkg::S_DRY:      begin cmd.op = odp_pkg::OP_DRY;      state_nxt = odp_pkg::S_WET_LO; end
      odp_pkg::S_WET_LO:   begin cmd.op = odp_pkg::OP_WET_LO;   state_nxt = odp_pkg::S_WET_HI; end
      odp_pkg::S_WET_HI:   begin cmd.op = odp_pkg::OP_WET_HI;   state_nxt = odp_pkg::S_WET_SUM; end
      odp_pkg::S_WET_SUM:  begin cmd.op = odp_pkg::OP_WET_SUM;  state_nxt = odp_pkg::S_GAIN_MUL; end
      odp_pkg::S_GAIN_MUL: begin cmd.op = odp_pkg::OP_GAIN_MUL; state_nxt = odp_pkg::S_GAIN; end
      odp_pkg::S_GAIN:     begin cmd.op = odp_pkg::OP_GAIN;     state_nxt = odp_pkg::S_CLIP_LOAD; end
      odp_pkg::S_CLIP_LOAD: begin
        cmd.op    = odp_pkg::OP_CLIP_LOAD;
        state_nxt = odp_pkg::S_CLIP_WAIT;
      end
      odp_pkg::S_CLIP_WAIT: begin
        if (status.div_done) state_nxt = odp_pkg::S_CLIP_END;
      end
      odp_pkg::S_CLIP_END: begin cmd.op = odp_pkg::OP_CLIP_END; state_nxt = odp_pkg::S_TONE_MUL; end
      odp_pkg::S_TONE_MUL: begin cmd.op = odp_pkg::OP_TONE_MUL; state_nxt = odp_pkg::S_TONE_ADD; end
      odp_pkg::S_TONE_ADD: begin cmd.op = odp_pkg::OP_TONE_ADD; state_nxt = odp_pkg::S_LVL_MUL; end
      odp_pkg::S_LVL_MUL:  begin cmd.op = odp_pkg::OP_LVL_MUL;  state_nxt = odp_pkg::S_LVL; end
      odp_pkg::S_LVL:      begin cmd.op = odp_pkg::OP_LVL;      state_nxt = odp_pkg::S_HP2_MUL; end
      odp_pkg::S_HP2_MUL:  begin cmd.op = odp_pkg::OP_HP2_MUL;  state_nxt = odp_pkg::S_HP2_ADD; end
      odp_pkg::S_HP2_ADD:  begin cmd.op = odp_pkg::OP_HP2_ADD;  state_nxt = odp_pkg::S_TS_MUL; end
      odp_pkg::S_TS_MUL:   begin cmd.op = odp_pkg::OP_TS_MUL;   state_nxt = odp_pkg::S_TS; end
      odp_pkg::S_TS:       begin cmd.op = odp_pkg::OP_TS;       state_nxt = odp_pkg::S_SQ; end
      odp_pkg::S_SQ:       begin cmd.op = odp_pkg::OP_SQ;       state_nxt = odp_pkg::S_NPREP; end
      odp_pkg::S_NPREP:    begin cmd.op = odp_pkg::OP_NPREP;    state_nxt = odp_pkg::S_NLO; end
      odp_pkg::S_NLO:      begin cmd.op = odp_pkg::OP_NLO;      state_nxt = odp_pkg::S_NHI; end
      odp_pkg::S_NHI:      begin cmd.op = odp_pkg::OP_NHI;      state_nxt = odp_pkg::S_NSUM; end
      odp_pkg::S_NSUM:     begin cmd.op = odp_pkg::OP_NSUM;     state_nxt = odp_pkg::S_TANH_WAIT; end
      odp_pkg::S_TANH_WAIT: begin
        if (status.div_done) state_nxt = odp_pkg::S_FINISH;
      end
      // The result register is loaded once the previous beat has left.
      odp_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = odp_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = odp_pkg::S_IDLE;
        end
      end
      default: state_nxt = odp_pkg::S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == odp_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> rtl/core/overdrive_pedal_sample_chain.sv
// Top level of the overdrive sample chain: registers, controller and datapath.
// Each accepted sample beat runs through a fixed step sequence on one shared
// multiplier and two 17-step restoring divisions (clipper and tanh), and the
// next sample is taken as soon as the controller is back in idle. The result
// register holds a finished sample until it is taken while the next sample
// is already accepted. Filter state is kept per channel and cleared by reset;
// configuration is written through a plain write port.
`timescale 1ns / 1ps
`default_nettype none
module overdrive_pedal_sample_chain #(
  parameter int CHANNELS = odp_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  odp_in_if.sink      in_beat,
  odp_out_if.source   out_beat,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);

  odp_pkg::cfg_t    cfg;
  odp_pkg::cmd_t    cmd;
  odp_pkg::status_t status;
  logic             in_ready, out_valid, out_channel;
  logic signed [15:0] out_sample;

  odp_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  odp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_beat.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_beat.ready),
    .status    (status),
    .cmd       (cmd)
  );

  odp_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .in_channel  (in_beat.channel),
    .in_sample   (in_beat.in_sample),
    .status      (status),
    .out_channel (out_channel),
    .out_sample  (out_sample)
  );

  assign in_beat.ready        = in_ready;
  assign out_beat.valid       = out_valid;
  assign out_beat.out_channel = out_channel;
  assign out_beat.out_sample  = out_sample;

endmodule
`default_nettype wire

>>> rtl/core/odp_checker.sv
// Port-level checker of the sample chain and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module odp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  logic [1:0] pend_r, pend_nxt;

  // Samples accepted but not yet delivered.
  always_comb begin
    pend_nxt = pend_r + 2'((in_valid && in_ready) ? 1 : 0)
                      - 2'((out_valid && out_ready) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else pend_r <= pend_nxt;
  end

  `ODP_ASSERT_RST(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
  `ODP_ASSERT_RST(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second sample taken")
  `ODP_ASSERT_RST(a_no_extra_out, out_valid |-> pend_r != 2'd0, "result without a sample")
  `ODP_ASSERT_RST(a_pend_bound, pend_r <= 2'd2, "too many samples in flight")

endmodule

bind overdrive_pedal_sample_chain odp_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_beat.valid),
  .in_ready  (in_beat.ready),
  .out_valid (out_beat.valid),
  .out_ready (out_beat.ready)
);
`default_nettype wire
